### rtl/pid_controller_clamped_terms_unit_macros.svh
// Assertion macros for the clamped-term PID controller.
// Taken in by `include from the files that assert; needs nothing else.
`ifndef PID_CONTROLLER_CLAMPED_TERMS_UNIT_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_TERMS_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PCTU_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PCTU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pctu_pkg.sv
// Shared constants, types and the scale-and-saturate function of the PID unit.
// No dependencies; every other RTL file but the macros header refers to it by scoped names.
`timescale 1ns / 1ps

package pctu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int ERR_W   = DATA_WIDTH + 1;        // setpoint minus measurement
    localparam int DERR_W  = DATA_WIDTH + 2;        // change of error
    localparam int MUL_W   = DATA_WIDTH + DERR_W;   // P and D products
    localparam int IPROD_W = DATA_WIDTH + ERR_W;    // integral increment product
    localparam int ACC_W   = DATA_WIDTH + FRAC_BITS;
    localparam int INC_EXP = 57;                    // increment limited to +/- 2^57
    localparam int INC_W   = INC_EXP + 2;
    localparam int SUM_W   = INC_W + 1;
    localparam int TOT_W   = DATA_WIDTH + 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd6;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic signed [IPROD_W-1:0] INC_HI =
        {{(IPROD_W-INC_EXP-1){1'b0}}, 1'b1, {INC_EXP{1'b0}}};
    localparam logic signed [IPROD_W-1:0] INC_LO = -INC_HI;

    typedef struct packed {
        t_word gain_prop;
        t_word gain_integ;
        t_word gain_deriv;
        t_word integ_max;
        t_word integ_min;
        t_word out_max;
        t_word out_min;
    } t_cfg;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
    } t_qitem;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_sts;

    typedef struct packed {
        logic                    stall;
        logic signed [ACC_W-1:0] acc;
    } t_back_sts;

    // floor(p / 2^FRAC_BITS), saturated to the signed data range
    function automatic t_word sat_scale(input logic signed [MUL_W-1:0] p);
        logic signed [MUL_W-1:0]      s;
        logic [MUL_W-DATA_WIDTH:0]    top;
        s   = p >>> FRAC_BITS;
        top = s[MUL_W-1:DATA_WIDTH-1];
        if ((&top) || !(|top)) begin
            return s[DATA_WIDTH-1:0];
        end else if (s[MUL_W-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

endpackage

### rtl/pctu_front.sv
// Front end: accepts samples, forms the error and its change since the last sample.
// Depends on pctu_pkg; pushes one entry per accepted sample into the queue.
`timescale 1ns / 1ps

module pctu_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [pctu_pkg::DATA_WIDTH-1:0] i_target_value,
    input  logic signed [pctu_pkg::DATA_WIDTH-1:0] i_measured_value,
    input  pctu_pkg::t_q_sts                   i_q_sts,
    output logic                               o_push,
    output pctu_pkg::t_qitem                   o_item
);

    logic signed [pctu_pkg::ERR_W-1:0]  r_prev_err;
    logic signed [pctu_pkg::ERR_W-1:0]  n_err;
    logic signed [pctu_pkg::ERR_W-1:0]  tgt_ext;
    logic signed [pctu_pkg::ERR_W-1:0]  meas_ext;
    logic signed [pctu_pkg::DERR_W-1:0] n_derr;
    logic                               accept;

    assign o_in_ready = !i_q_sts.full;
    assign accept     = i_in_valid && o_in_ready;

    assign tgt_ext  = pctu_pkg::ERR_W'(i_target_value);
    assign meas_ext = pctu_pkg::ERR_W'(i_measured_value);
    assign n_err    = tgt_ext - meas_ext;
    assign n_derr   = pctu_pkg::DERR_W'(n_err) - pctu_pkg::DERR_W'(r_prev_err);

    assign o_push      = accept;
    assign o_item.err  = n_err;
    assign o_item.derr = n_derr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
        end else if (accept) begin
            r_prev_err <= n_err;
        end
    end

endmodule

### rtl/pctu_fifo.sv
// Short queue between the front end and the arithmetic back end.
// Depends on pctu_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pctu_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pctu_pkg::t_qitem  i_item,
    input  logic              i_pop,
    output pctu_pkg::t_qitem  o_item,
    output pctu_pkg::t_q_sts  o_sts
);

    pctu_pkg::t_qitem               r_mem [pctu_pkg::Q_DEPTH];
    logic [pctu_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [pctu_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [pctu_pkg::Q_CNT_W-1:0]   r_count;

    function automatic logic [pctu_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [pctu_pkg::Q_PTR_W-1:0] p
    );
        if (p == pctu_pkg::Q_PTR_W'(pctu_pkg::Q_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    assign o_sts.full  = (r_count == pctu_pkg::Q_CNT_W'(pctu_pkg::Q_DEPTH));
    assign o_sts.empty = (r_count == '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/pctu_back.sv
// Back end: three-stage pipeline for products, term limiting with the integrator,
// and the clamped sum in the output register. Depends on pctu_pkg.
`timescale 1ns / 1ps

module pctu_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pctu_pkg::t_cfg                         i_cfg,
    input  logic                                   i_q_valid,
    input  pctu_pkg::t_qitem                       i_q_item,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pctu_pkg::DATA_WIDTH-1:0] o_control_out,
    output logic                                   o_integ_clamped,
    output logic                                   o_out_clamped,
    output pctu_pkg::t_back_sts                    o_sts
);

    logic                                   adv;

    // stage 1: products
    logic                                   r_s1_valid;
    logic signed [pctu_pkg::MUL_W-1:0]      r_prod_p;
    logic signed [pctu_pkg::MUL_W-1:0]      r_prod_d;
    logic signed [pctu_pkg::IPROD_W-1:0]    r_prod_i;
    logic signed [pctu_pkg::MUL_W-1:0]      n_prod_p;
    logic signed [pctu_pkg::MUL_W-1:0]      n_prod_d;
    logic signed [pctu_pkg::IPROD_W-1:0]    n_prod_i;

    // stage 2: terms and integrator
    logic                                   r_s2_valid;
    logic signed [pctu_pkg::ACC_W-1:0]      r_acc;
    pctu_pkg::t_word                        r_p_term;
    pctu_pkg::t_word                        r_i_term;
    pctu_pkg::t_word                        r_d_term;
    logic                                   r_s2_iclamp;
    logic signed [pctu_pkg::IPROD_W-1:0]    inc_lim;
    logic signed [pctu_pkg::SUM_W-1:0]      acc_sum;
    logic signed [pctu_pkg::SUM_W-1:0]      ilim_hi;
    logic signed [pctu_pkg::SUM_W-1:0]      ilim_lo;
    logic signed [pctu_pkg::SUM_W-1:0]      n_acc_wide;
    logic signed [pctu_pkg::ACC_W-1:0]      n_acc;
    logic                                   n_iclamp;

    // stage 3: output register
    logic                                   r_out_valid;
    pctu_pkg::t_word                        r_control_out;
    logic                                   r_integ_clamped;
    logic                                   r_out_clamped;
    logic signed [pctu_pkg::TOT_W-1:0]      total;
    logic signed [pctu_pkg::TOT_W-1:0]      olim_hi;
    logic signed [pctu_pkg::TOT_W-1:0]      olim_lo;
    pctu_pkg::t_word                        n_control_out;
    logic                                   n_oclamp;

    // the whole pipeline moves when the output register is free or being taken
    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = adv && i_q_valid;

    assign n_prod_p = pctu_pkg::MUL_W'(i_cfg.gain_prop) * pctu_pkg::MUL_W'(i_q_item.err);
    assign n_prod_d = pctu_pkg::MUL_W'(i_cfg.gain_deriv) * pctu_pkg::MUL_W'(i_q_item.derr);
    assign n_prod_i = pctu_pkg::IPROD_W'(i_cfg.gain_integ)
                    * pctu_pkg::IPROD_W'(i_q_item.err);

    always_comb begin
        priority if (r_prod_i > pctu_pkg::INC_HI) begin
            inc_lim = pctu_pkg::INC_HI;
        end else if (r_prod_i < pctu_pkg::INC_LO) begin
            inc_lim = pctu_pkg::INC_LO;
        end else begin
            inc_lim = r_prod_i;
        end
    end

    assign acc_sum = pctu_pkg::SUM_W'(r_acc)
                   + pctu_pkg::SUM_W'($signed(inc_lim[pctu_pkg::INC_W-1:0]));
    assign ilim_hi = pctu_pkg::SUM_W'(i_cfg.integ_max) <<< pctu_pkg::FRAC_BITS;
    assign ilim_lo = pctu_pkg::SUM_W'(i_cfg.integ_min) <<< pctu_pkg::FRAC_BITS;

    // with inverted limits, a sum above the upper limit takes the upper limit and any other sum the lower
    always_comb begin
        n_iclamp = 1'b1;
        priority if (acc_sum > ilim_hi) begin
            n_acc_wide = ilim_hi;
        end else if (acc_sum < ilim_lo) begin
            n_acc_wide = ilim_lo;
        end else begin
            n_acc_wide = acc_sum;
            n_iclamp   = 1'b0;
        end
    end

    assign n_acc = n_acc_wide[pctu_pkg::ACC_W-1:0];

    assign total = pctu_pkg::TOT_W'(r_p_term) + pctu_pkg::TOT_W'(r_i_term)
                 + pctu_pkg::TOT_W'(r_d_term);
    assign olim_hi = pctu_pkg::TOT_W'(i_cfg.out_max);
    assign olim_lo = pctu_pkg::TOT_W'(i_cfg.out_min);

    always_comb begin
        n_oclamp = 1'b1;
        priority if (total > olim_hi) begin
            n_control_out = i_cfg.out_max;
        end else if (total < olim_lo) begin
            n_control_out = i_cfg.out_min;
        end else begin
            n_control_out = total[pctu_pkg::DATA_WIDTH-1:0];
            n_oclamp      = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod_p        <= n_prod_p;
            r_prod_d        <= n_prod_d;
            r_prod_i        <= n_prod_i;
            r_p_term        <= pctu_pkg::sat_scale(r_prod_p);
            r_d_term        <= pctu_pkg::sat_scale(r_prod_d);
            r_i_term        <= n_acc[pctu_pkg::ACC_W-1:pctu_pkg::FRAC_BITS];
            r_s2_iclamp     <= n_iclamp;
            r_control_out   <= n_control_out;
            r_integ_clamped <= r_s2_iclamp;
            r_out_clamped   <= n_oclamp;
        end
    end

    // control and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (adv) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (r_s1_valid) begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_control_out   = r_control_out;
    assign o_integ_clamped = r_integ_clamped;
    assign o_out_clamped   = r_out_clamped;
    assign o_sts.stall     = r_out_valid && !i_out_ready;
    assign o_sts.acc       = r_acc;

endmodule

### rtl/pid_controller_clamped_terms_unit.sv
// Top level of the clamped-term PID controller: configuration registers,
// front end, queue and back end. Depends on pctu_pkg and the macros header.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  sample   | i_in_valid / o_in_ready     | i_target_value, i_measured_value
//  result   | o_out_valid / i_out_ready   | o_control_out, o_integ_clamped, o_out_clamped
//  config   | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// One sample per cycle sustained unless stalled; a sample passes the queue, product,
// term and output registers. The integrator add and clamp in the second back-end stage
// closes the loop. A stalled result freezes the back end; the two-entry queue takes
// samples until full. Synchronous reset clears integrator, last error, queue and config.
`timescale 1ns / 1ps
`include "pid_controller_clamped_terms_unit_macros.svh"

module pid_controller_clamped_terms_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pctu_pkg::DATA_WIDTH-1:0] i_target_value,
    input  logic signed [pctu_pkg::DATA_WIDTH-1:0] i_measured_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [pctu_pkg::DATA_WIDTH-1:0] o_control_out,
    output logic                                   o_integ_clamped,
    output logic                                   o_out_clamped,
    input  logic                                   i_cfg_we,
    input  logic [pctu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pctu_pkg::DATA_WIDTH-1:0]        i_cfg_data
);

    pctu_pkg::t_cfg      r_cfg;
    pctu_pkg::t_q_sts    q_sts;
    pctu_pkg::t_qitem    push_item;
    pctu_pkg::t_qitem    head_item;
    pctu_pkg::t_back_sts back_sts;
    logic                push;
    logic                pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= '0;
            r_cfg.gain_integ <= '0;
            r_cfg.gain_deriv <= '0;
            r_cfg.integ_max  <= pctu_pkg::WORD_MAX;
            r_cfg.integ_min  <= pctu_pkg::WORD_MIN;
            r_cfg.out_max    <= pctu_pkg::WORD_MAX;
            r_cfg.out_min    <= pctu_pkg::WORD_MIN;
        end else if (i_cfg_we) begin
            // drop writes to unknown indexes
            case (i_cfg_index)
                pctu_pkg::REG_GAIN_PROP:  r_cfg.gain_prop  <= i_cfg_data;
                pctu_pkg::REG_GAIN_INTEG: r_cfg.gain_integ <= i_cfg_data;
                pctu_pkg::REG_GAIN_DERIV: r_cfg.gain_deriv <= i_cfg_data;
                pctu_pkg::REG_INTEG_MAX:  r_cfg.integ_max  <= i_cfg_data;
                pctu_pkg::REG_INTEG_MIN:  r_cfg.integ_min  <= i_cfg_data;
                pctu_pkg::REG_OUT_MAX:    r_cfg.out_max    <= i_cfg_data;
                pctu_pkg::REG_OUT_MIN:    r_cfg.out_min    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pctu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_target_value   (i_target_value),
        .i_measured_value (i_measured_value),
        .i_q_sts          (q_sts),
        .o_push           (push),
        .o_item           (push_item)
    );

    pctu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_sts   (q_sts)
    );

    pctu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (!q_sts.empty),
        .i_q_item        (head_item),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_control_out   (o_control_out),
        .o_integ_clamped (o_integ_clamped),
        .o_out_clamped   (o_out_clamped),
        .o_sts           (back_sts)
    );

    `PCTU_ASSERT_NEXT(a_stall_holds_integ, i_clk, i_rst_n, back_sts.stall, $stable(back_sts.acc), "integrator moved during output stall")
    `PCTU_ASSERT_NEXT(a_accept_fills_queue, i_clk, i_rst_n, i_in_valid && o_in_ready, !q_sts.empty, "accepted sample missing from queue")
    `PCTU_ASSERT_NEXT(a_full_stall_blocks, i_clk, i_rst_n, back_sts.stall && q_sts.full, !o_in_ready, "input ready with full queue behind stall")

endmodule
